@@ rtl/core/lwrl_pkg.sv @@
`default_nettype none

package lwrl_pkg;

  // Default build values for the top-level parameters.
  localparam int DEPTH_DEF       = 1024;
  localparam int SAMPLE_BITS_DEF = 16;

  // Fixed widths of the channel fields.
  localparam int IN_SAMPLE_W = 16;
  localparam int LIMIT_W     = 16;
  localparam int OUT_POS_W   = 11;

  // Queue select codes for the shared compare path.
  localparam logic Q_MIN = 1'b0;
  localparam logic Q_MAX = 1'b1;

  typedef struct packed {
    logic [IN_SAMPLE_W-1:0] sample;
    logic                   last_sample;
  } in_item_t;

  typedef struct packed {
    logic [OUT_POS_W-1:0] position;
    logic [OUT_POS_W-1:0] window_start;
    logic [OUT_POS_W-1:0] window_length;
    logic [OUT_POS_W-1:0] best_length;
    logic [OUT_POS_W-1:0] best_count;
    logic                 is_best;
    logic                 overflow;
    logic                 last_result;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BACK_RD,
    ST_BACK_CMP,
    ST_PUSH,
    ST_WIN,
    ST_TRIM,
    ST_TRIM_LD,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

@@ rtl/core/longest_window_range_within_limit.sv @@
// Sequencing: an accepted sample pops dominated back entries from the minimum queue and is
// pushed there, then the same for the maximum queue; the window start then jumps past stale
// heads. A sample beyond DEPTH is flagged as overflow and goes straight to the result.
// Throughput: one item at a time, as the input stalls while the sequencer is busy; a stalled
// result holds the sequencer in its output state and so holds off the input.
// Reset (rst_n, synchronous, active low) clears sequencer, pointers, counters and range limit.
`default_nettype none

module longest_window_range_within_limit #(
  parameter int DEPTH       = lwrl_pkg::DEPTH_DEF,
  parameter int SAMPLE_BITS = lwrl_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // Input channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire lwrl_pkg::in_item_t             in_data,
  // Result channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output lwrl_pkg::out_item_t                 out_data,
  // Range limit register
  input  wire logic                           cfg_wr_en,
  input  wire logic [lwrl_pkg::LIMIT_W-1:0]   cfg_wr_data
);

  // Index width of a queue memory, and width of counts and positions, which reach DEPTH.
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  // Width at which the max-minus-min difference is compared with the limit.
  localparam int CMP_W = (SAMPLE_BITS > lwrl_pkg::LIMIT_W) ? SAMPLE_BITS : lwrl_pkg::LIMIT_W;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);

  // One stored queue entry: sample value and its one-based position.
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] val;
    logic [CNT_W-1:0]       pos;
  } entry_t;

  // Control of one monotonic queue. The head entry is cached so that the window check
  // never has to wait for a memory read.
  typedef struct packed {
    logic [IDX_W-1:0]       front;
    logic [IDX_W-1:0]       back;
    logic [CNT_W-1:0]       count;
    logic [SAMPLE_BITS-1:0] hval;
    logic [CNT_W-1:0]       hpos;
  } queue_t;

  function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
    ptr_inc = (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] ptr_dec(input logic [IDX_W-1:0] p);
    ptr_dec = (p == '0) ? LAST_IDX : p - 1'b1;
  endfunction

  // Sequencer and item registers
  lwrl_pkg::state_t              state_r, state_nxt;
  logic                          qsel_r, qsel_nxt;
  logic [SAMPLE_BITS-1:0]        x_r, x_nxt;
  logic [CNT_W-1:0]              pos_r, pos_nxt;
  logic                          last_r, last_nxt;
  logic                          ovf_r, ovf_nxt;

  // Sequence state
  logic [CNT_W-1:0]              idx_r, idx_nxt;
  logic [CNT_W-1:0]              left_r, left_nxt;
  logic [CNT_W-1:0]              best_len_r, best_len_nxt;
  logic [CNT_W-1:0]              best_cnt_r, best_cnt_nxt;
  queue_t                        minq_r, minq_nxt;
  queue_t                        maxq_r, maxq_nxt;
  logic [lwrl_pkg::LIMIT_W-1:0]  limit_r;

  // Output register
  logic                          out_valid_r, out_valid_nxt;
  lwrl_pkg::out_item_t           out_r, out_nxt;

  // Queue memories, one write and one registered read port each.
  entry_t                        min_mem [DEPTH];
  entry_t                        max_mem [DEPTH];
  entry_t                        min_rd_r, max_rd_r;
  logic [IDX_W-1:0]              rd_addr;
  logic [IDX_W-1:0]              wr_addr;
  logic                          min_we, max_we;
  entry_t                        wr_entry;

  // Shared datapath signals
  queue_t                        cur_q, cur_nxt;
  entry_t                        rd_entry;
  logic                          back_drop;
  logic [SAMPLE_BITS-1:0]        span;
  logic                          too_wide;
  logic [CNT_W-1:0]              min_hpos;
  logic [CNT_W-1:0]              win_len;
  logic                          clear_seq;

  assign in_stall  = (state_r != lwrl_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // The queue currently worked on is picked by qsel_r; all pops, pushes and front
  // drops go through this one path.
  assign cur_q    = (qsel_r == lwrl_pkg::Q_MAX) ? maxq_r : minq_r;
  assign rd_entry = (qsel_r == lwrl_pkg::Q_MAX) ? max_rd_r : min_rd_r;

  // A back entry is dominated when it is larger (minimum queue) or smaller (maximum queue)
  // than the new sample.
  assign back_drop = (qsel_r == lwrl_pkg::Q_MAX) ? (rd_entry.val < x_r) : (rd_entry.val > x_r);

  // Both queues hold the current sample, so the maximum head is never below the minimum head.
  assign span     = maxq_r.hval - minq_r.hval;
  assign too_wide = (CMP_W'(span) > CMP_W'(limit_r)) && (left_r < pos_r);
  assign min_hpos = (minq_r.hpos < maxq_r.hpos) ? minq_r.hpos : maxq_r.hpos;
  assign win_len  = pos_r - left_r + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    qsel_nxt      = qsel_r;
    x_nxt         = x_r;
    pos_nxt       = pos_r;
    last_nxt      = last_r;
    ovf_nxt       = ovf_r;
    idx_nxt       = idx_r;
    left_nxt      = left_r;
    best_len_nxt  = best_len_r;
    best_cnt_nxt  = best_cnt_r;
    minq_nxt      = minq_r;
    maxq_nxt      = maxq_r;
    cur_nxt       = cur_q;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    rd_addr       = cur_q.back;
    wr_addr       = ptr_inc(cur_q.back);
    wr_entry      = '{val: x_r, pos: pos_r};
    min_we        = 1'b0;
    max_we        = 1'b0;
    clear_seq     = 1'b0;

    case (state_r)
      lwrl_pkg::ST_IDLE: begin
        if (in_valid) begin
          x_nxt    = SAMPLE_BITS'(in_data.sample);
          last_nxt = in_data.last_sample;
          qsel_nxt = lwrl_pkg::Q_MIN;
          if (idx_r >= DEPTH_C) begin
            ovf_nxt   = 1'b1;
            state_nxt = lwrl_pkg::ST_OUT;
          end else begin
            ovf_nxt   = 1'b0;
            pos_nxt   = idx_r + 1'b1;
            idx_nxt   = idx_r + 1'b1;
            state_nxt = lwrl_pkg::ST_BACK_RD;
          end
        end
      end

      lwrl_pkg::ST_BACK_RD: begin
        rd_addr   = cur_q.back;
        state_nxt = (cur_q.count != '0) ? lwrl_pkg::ST_BACK_CMP : lwrl_pkg::ST_PUSH;
      end

      lwrl_pkg::ST_BACK_CMP: begin
        if (back_drop) begin
          cur_nxt.count = cur_q.count - 1'b1;
          cur_nxt.back  = ptr_dec(cur_q.back);
          rd_addr       = ptr_dec(cur_q.back);
          if (cur_nxt.count == '0) begin
            state_nxt = lwrl_pkg::ST_PUSH;
          end
        end else begin
          state_nxt = lwrl_pkg::ST_PUSH;
        end
      end

      lwrl_pkg::ST_PUSH: begin
        wr_addr       = ptr_inc(cur_q.back);
        min_we        = (qsel_r == lwrl_pkg::Q_MIN);
        max_we        = (qsel_r == lwrl_pkg::Q_MAX);
        cur_nxt.back  = wr_addr;
        cur_nxt.count = cur_q.count + 1'b1;
        // A queue that was emptied by the pops gets the new sample as its head.
        if (cur_q.count == '0) begin
          cur_nxt.hval = x_r;
          cur_nxt.hpos = pos_r;
        end
        if (qsel_r == lwrl_pkg::Q_MIN) begin
          qsel_nxt  = lwrl_pkg::Q_MAX;
          state_nxt = lwrl_pkg::ST_BACK_RD;
        end else begin
          state_nxt = lwrl_pkg::ST_WIN;
        end
      end

      lwrl_pkg::ST_WIN: begin
        // Advancing the start one step at a time changes nothing until it passes the
        // older head, so the start jumps straight past it.
        if (too_wide) begin
          left_nxt  = min_hpos + 1'b1;
          qsel_nxt  = (minq_r.hpos == min_hpos) ? lwrl_pkg::Q_MIN : lwrl_pkg::Q_MAX;
          state_nxt = lwrl_pkg::ST_TRIM;
        end else begin
          state_nxt = lwrl_pkg::ST_OUT;
        end
      end

      lwrl_pkg::ST_TRIM: begin
        cur_nxt.front = ptr_inc(cur_q.front);
        cur_nxt.count = cur_q.count - 1'b1;
        rd_addr       = ptr_inc(cur_q.front);
        state_nxt     = lwrl_pkg::ST_TRIM_LD;
      end

      lwrl_pkg::ST_TRIM_LD: begin
        cur_nxt.hval = rd_entry.val;
        cur_nxt.hpos = rd_entry.pos;
        if ((qsel_r == lwrl_pkg::Q_MIN) && (maxq_r.hpos < left_r)) begin
          qsel_nxt  = lwrl_pkg::Q_MAX;
          state_nxt = lwrl_pkg::ST_TRIM;
        end else begin
          state_nxt = lwrl_pkg::ST_WIN;
        end
      end

      lwrl_pkg::ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          if (ovf_r) begin
            out_nxt.position      = '0;
            out_nxt.window_start  = '0;
            out_nxt.window_length = '0;
            out_nxt.is_best       = 1'b0;
          end else begin
            if (win_len > best_len_r) begin
              best_len_nxt = win_len;
              best_cnt_nxt = CNT_W'(1);
            end else if (win_len == best_len_r) begin
              best_cnt_nxt = best_cnt_r + 1'b1;
            end
            out_nxt.position      = lwrl_pkg::OUT_POS_W'(pos_r);
            out_nxt.window_start  = lwrl_pkg::OUT_POS_W'(left_r);
            out_nxt.window_length = lwrl_pkg::OUT_POS_W'(win_len);
            out_nxt.is_best       = (win_len == best_len_nxt);
          end
          out_nxt.best_length = lwrl_pkg::OUT_POS_W'(best_len_nxt);
          out_nxt.best_count  = lwrl_pkg::OUT_POS_W'(best_cnt_nxt);
          out_nxt.overflow    = ovf_r;
          out_nxt.last_result = last_r;
          clear_seq           = last_r;
          state_nxt           = lwrl_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = lwrl_pkg::ST_IDLE;
      end
    endcase

    if (qsel_r == lwrl_pkg::Q_MAX) begin
      maxq_nxt = cur_nxt;
    end else begin
      minq_nxt = cur_nxt;
    end

    // The last sample of a sequence returns the counters, window start and queue pointers to reset.
    if (clear_seq) begin
      idx_nxt        = '0;
      left_nxt       = CNT_W'(1);
      best_len_nxt   = '0;
      best_cnt_nxt   = '0;
      minq_nxt.front = '0;
      minq_nxt.back  = LAST_IDX;
      minq_nxt.count = '0;
      maxq_nxt.front = '0;
      maxq_nxt.back  = LAST_IDX;
      maxq_nxt.count = '0;
    end
  end

  // The cached queue heads are payload and carry no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= lwrl_pkg::ST_IDLE;
      qsel_r         <= lwrl_pkg::Q_MIN;
      idx_r          <= '0;
      left_r         <= CNT_W'(1);
      best_len_r     <= '0;
      best_cnt_r     <= '0;
      minq_r.front   <= '0;
      minq_r.back    <= LAST_IDX;
      minq_r.count   <= '0;
      maxq_r.front   <= '0;
      maxq_r.back    <= LAST_IDX;
      maxq_r.count   <= '0;
      limit_r        <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      qsel_r         <= qsel_nxt;
      idx_r          <= idx_nxt;
      left_r         <= left_nxt;
      best_len_r     <= best_len_nxt;
      best_cnt_r     <= best_cnt_nxt;
      minq_r.front   <= minq_nxt.front;
      minq_r.back    <= minq_nxt.back;
      minq_r.count   <= minq_nxt.count;
      minq_r.hval    <= minq_nxt.hval;
      minq_r.hpos    <= minq_nxt.hpos;
      maxq_r.front   <= maxq_nxt.front;
      maxq_r.back    <= maxq_nxt.back;
      maxq_r.count   <= maxq_nxt.count;
      maxq_r.hval    <= maxq_nxt.hval;
      maxq_r.hpos    <= maxq_nxt.hpos;
      out_valid_r    <= out_valid_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    x_r         <= x_nxt;
    pos_r       <= pos_nxt;
    last_r      <= last_nxt;
    ovf_r       <= ovf_nxt;
    out_r       <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (min_we) begin
      min_mem[wr_addr] <= wr_entry;
    end
    min_rd_r <= min_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (max_we) begin
      max_mem[wr_addr] <= wr_entry;
    end
    max_rd_r <= max_mem[rd_addr];
  end

  // A queue never holds more entries than it has slots.
  assert property (@(posedge clk) disable iff (!rst_n)
    (minq_r.count <= DEPTH_C) && (maxq_r.count <= DEPTH_C))
    else $error("queue occupancy beyond depth");

  // A front drop always leaves the current sample behind it in the queue.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lwrl_pkg::ST_TRIM) |-> (cur_q.count > CNT_W'(1)))
    else $error("front drop would empty a queue");

  // The window of an accepted sample starts at or before that sample.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lwrl_pkg::ST_OUT && !ovf_r) |-> (left_r <= pos_r && left_r != '0))
    else $error("window start past its end");

  // A result appears only as the sequencer finishes an item.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == lwrl_pkg::ST_OUT))
    else $error("result without a finished item");

endmodule

`default_nettype wire
